### sv/value_to_color_ramp_defines.svh
// assertion helpers for the value to color ramp block
`ifndef VALUE_TO_COLOR_RAMP_DEFINES_SVH
`define VALUE_TO_COLOR_RAMP_DEFINES_SVH

`ifndef SYNTHESIS

`define VCR_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`define VCR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define VCR_ASSERT_SAME(label, clk, rst, ante, cons)

`define VCR_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### sv/vcr_pkg.sv
`timescale 1ns / 1ps

package vcr_pkg;

   localparam int VALUE_BITS_DEFAULT    = 24;
   localparam int FRACTION_BITS_DEFAULT = 16;
   localparam int HIGH_BOUND_RESET      = 1000;
   localparam int CSR_INDEX_BITS        = 1;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_LOW_BOUND  = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HIGH_BOUND = 1'b1;

   localparam logic [7:0] LEVEL_FULL = 8'hFF;
   localparam logic [7:0] LEVEL_NONE = 8'h00;

   typedef enum logic [1:0] {
      KIND_BLACK = 2'd0,
      KIND_GREEN = 2'd1,
      KIND_RED   = 2'd2,
      KIND_RAMP  = 2'd3
   } kind_type;

   typedef struct packed {
      logic     valid;
      kind_type kind;
   } ctrl_type;

endpackage

### sv/vcr_front.sv
`timescale 1ns / 1ps

module vcr_front #(
   parameter int VALUE_BITS = vcr_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  logic signed [VALUE_BITS-1:0] sample_value,
   input  logic                         sample_invalid,
   input  logic signed [VALUE_BITS-1:0] low_bound,
   input  logic signed [VALUE_BITS-1:0] high_bound,
   output vcr_pkg::ctrl_type            ctrl_out,
   output logic [VALUE_BITS-1:0]        num_out,
   output logic [VALUE_BITS-1:0]        den_out
);

   logic                  valid_ff, valid_in;
   vcr_pkg::kind_type     kind_ff, kind_in;
   logic [VALUE_BITS-1:0] num_ff, num_in;
   logic [VALUE_BITS-1:0] den_ff, den_in;
   logic [VALUE_BITS:0]   num_wide;
   logic [VALUE_BITS:0]   den_wide;

   always_comb begin
      num_wide = {sample_value[VALUE_BITS-1], sample_value}
                 - {low_bound[VALUE_BITS-1], low_bound};
      den_wide = {high_bound[VALUE_BITS-1], high_bound}
                 - {low_bound[VALUE_BITS-1], low_bound};
      num_in   = num_wide[VALUE_BITS-1:0];
      den_in   = den_wide[VALUE_BITS-1:0];
      valid_in = in_valid;
      priority if (sample_invalid) begin
         kind_in = vcr_pkg::KIND_BLACK;
      end else if (sample_value < low_bound) begin
         kind_in = vcr_pkg::KIND_GREEN;
      end else if (sample_value >= high_bound) begin
         kind_in = vcr_pkg::KIND_RED;
      end else begin
         kind_in = vcr_pkg::KIND_RAMP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      num_ff  <= num_in;
      den_ff  <= den_in;
   end

   assign ctrl_out.valid = valid_ff;
   assign ctrl_out.kind  = kind_ff;
   assign num_out        = num_ff;
   assign den_out        = den_ff;

endmodule

### sv/vcr_div_stage.sv
`timescale 1ns / 1ps

module vcr_div_stage #(
   parameter int VALUE_BITS    = vcr_pkg::VALUE_BITS_DEFAULT,
   parameter int FRACTION_BITS = vcr_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  vcr_pkg::ctrl_type          ctrl_in,
   input  logic [VALUE_BITS-1:0]      rem_in,
   input  logic [VALUE_BITS-1:0]      den_in,
   input  logic [FRACTION_BITS:0]     quo_in,
   output vcr_pkg::ctrl_type          ctrl_out,
   output logic [VALUE_BITS-1:0]      rem_out,
   output logic [VALUE_BITS-1:0]      den_out,
   output logic [FRACTION_BITS:0]     quo_out
);

   logic                   valid_ff;
   vcr_pkg::kind_type      kind_ff;
   logic [VALUE_BITS-1:0]  rem_ff, rem_next_in;
   logic [VALUE_BITS-1:0]  den_ff;
   logic [FRACTION_BITS:0] quo_ff, quo_next_in;
   logic [VALUE_BITS:0]    shifted;
   logic [VALUE_BITS:0]    diff;
   logic                   fits;

   // one restoring step: shift, trial subtract, keep on no borrow
   always_comb begin
      shifted     = {rem_in, 1'b0};
      diff        = shifted - {1'b0, den_in};
      fits        = ~diff[VALUE_BITS];
      rem_next_in = fits ? diff[VALUE_BITS-1:0] : shifted[VALUE_BITS-1:0];
      quo_next_in = {quo_in[FRACTION_BITS-1:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= ctrl_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= ctrl_in.kind;
      rem_ff  <= rem_next_in;
      den_ff  <= den_in;
      quo_ff  <= quo_next_in;
   end

   assign ctrl_out.valid = valid_ff;
   assign ctrl_out.kind  = kind_ff;
   assign rem_out        = rem_ff;
   assign den_out        = den_ff;
   assign quo_out        = quo_ff;

endmodule

### sv/vcr_back.sv
`timescale 1ns / 1ps

module vcr_back #(
   parameter int FRACTION_BITS = vcr_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  vcr_pkg::ctrl_type      ctrl_in,
   input  logic [FRACTION_BITS:0] quo_in,
   output logic                   strobe,
   output logic [7:0]             red_level,
   output logic [7:0]             green_level,
   output logic [7:0]             blue_level
);

   logic                       strobe_ff;
   logic [7:0]                 red_ff, red_in;
   logic [7:0]                 green_ff, green_in;
   logic [FRACTION_BITS-1:0]   frac;
   logic [FRACTION_BITS+7:0]   scaled;
   logic [7:0]                 step;

   // frac * 255 as frac * 256 - frac, then drop the fraction bits
   always_comb begin
      frac   = quo_in[FRACTION_BITS-1:0];
      scaled = {frac, 8'h00} - {8'h00, frac};
      step   = scaled[FRACTION_BITS+7:FRACTION_BITS];
      unique case (ctrl_in.kind)
         vcr_pkg::KIND_BLACK: begin
            red_in   = vcr_pkg::LEVEL_NONE;
            green_in = vcr_pkg::LEVEL_NONE;
         end
         vcr_pkg::KIND_GREEN: begin
            red_in   = vcr_pkg::LEVEL_NONE;
            green_in = vcr_pkg::LEVEL_FULL;
         end
         vcr_pkg::KIND_RED: begin
            red_in   = vcr_pkg::LEVEL_FULL;
            green_in = vcr_pkg::LEVEL_NONE;
         end
         vcr_pkg::KIND_RAMP: begin
            if (quo_in[FRACTION_BITS]) begin
               red_in   = vcr_pkg::LEVEL_FULL;
               green_in = vcr_pkg::LEVEL_FULL - step;
            end else begin
               red_in   = vcr_pkg::LEVEL_NONE + step;
               green_in = vcr_pkg::LEVEL_FULL;
            end
         end
         default: begin
            red_in   = vcr_pkg::LEVEL_NONE;
            green_in = vcr_pkg::LEVEL_NONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= ctrl_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      red_ff   <= red_in;
      green_ff <= green_in;
   end

   assign strobe      = strobe_ff;
   assign red_level   = red_ff;
   assign green_level = green_ff;
   assign blue_level  = vcr_pkg::LEVEL_NONE;

endmodule

### sv/value_to_color_ramp.sv
`timescale 1ns / 1ps
`include "value_to_color_ramp_defines.svh"

// Maps a signed sample to a green-yellow-red color. busy is always low: a new
// sample may be started in every cycle, and each one produces exactly one
// result, shown for one cycle with rsp_strobe. The result passes through one
// input stage for the bound compares, the ramp position divider, which
// resolves one quotient bit per pipeline stage, and one output register.
// Results cannot be held off, so the receiver must take every strobed
// transfer. The bound registers are to be written only while no sample is
// in flight.
module value_to_color_ramp #(
   parameter int VALUE_BITS    = vcr_pkg::VALUE_BITS_DEFAULT,
   parameter int FRACTION_BITS = vcr_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic signed [VALUE_BITS-1:0]          req_sample_value,
   input  logic                                  req_sample_invalid,
   output logic                                  rsp_strobe,
   output logic [7:0]                            rsp_red_level,
   output logic [7:0]                            rsp_green_level,
   output logic [7:0]                            rsp_blue_level,
   input  logic                                  csr_wen,
   input  logic [vcr_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [VALUE_BITS-1:0]                 csr_wdata
);

   localparam int DIV_STAGES = FRACTION_BITS + 1;
   localparam int LATENCY    = FRACTION_BITS + 3;

   logic signed [VALUE_BITS-1:0] low_bound_ff;
   logic signed [VALUE_BITS-1:0] high_bound_ff;

   vcr_pkg::ctrl_type                      ctrl_chain [DIV_STAGES+1];
   logic [DIV_STAGES:0][VALUE_BITS-1:0]    rem_chain;
   logic [DIV_STAGES:0][VALUE_BITS-1:0]    den_chain;
   logic [DIV_STAGES:0][FRACTION_BITS:0]   quo_chain;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         low_bound_ff  <= '0;
         high_bound_ff <= VALUE_BITS'(vcr_pkg::HIGH_BOUND_RESET);
      end else if (csr_wen) begin
         unique case (csr_index)
            vcr_pkg::CSR_LOW_BOUND:  low_bound_ff  <= csr_wdata;
            vcr_pkg::CSR_HIGH_BOUND: high_bound_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   vcr_front #(
      .VALUE_BITS (VALUE_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (start & ~busy),
      .sample_value   (req_sample_value),
      .sample_invalid (req_sample_invalid),
      .low_bound      (low_bound_ff),
      .high_bound     (high_bound_ff),
      .ctrl_out       (ctrl_chain[0]),
      .num_out        (rem_chain[0]),
      .den_out        (den_chain[0])
   );

   assign quo_chain[0] = '0;

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
      vcr_div_stage #(
         .VALUE_BITS    (VALUE_BITS),
         .FRACTION_BITS (FRACTION_BITS)
      ) u_stage (
         .clock    (clock),
         .reset    (reset),
         .ctrl_in  (ctrl_chain[k]),
         .rem_in   (rem_chain[k]),
         .den_in   (den_chain[k]),
         .quo_in   (quo_chain[k]),
         .ctrl_out (ctrl_chain[k+1]),
         .rem_out  (rem_chain[k+1]),
         .den_out  (den_chain[k+1]),
         .quo_out  (quo_chain[k+1])
      );
   end

   vcr_back #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .ctrl_in     (ctrl_chain[DIV_STAGES]),
      .quo_in      (quo_chain[DIV_STAGES]),
      .strobe      (rsp_strobe),
      .red_level   (rsp_red_level),
      .green_level (rsp_green_level),
      .blue_level  (rsp_blue_level)
   );

   // every started sample comes out as a strobed result
   `VCR_ASSERT_SAME(a_latency, clock, reset, start && !busy, ##LATENCY rsp_strobe)
   // black only for a sample marked invalid
   `VCR_ASSERT_SAME(a_black_invalid, clock, reset, rsp_strobe && rsp_red_level == 8'h00 && rsp_green_level == 8'h00, $past(req_sample_invalid, LATENCY))
   // ramp colors always keep one channel at full
   `VCR_ASSERT_SAME(a_one_full, clock, reset, rsp_strobe && !$past(req_sample_invalid, LATENCY), rsp_red_level == 8'hFF || rsp_green_level == 8'hFF)
   // no result without a matching start
   `VCR_ASSERT_NEXT(a_no_spurious, clock, reset, !start, ##(LATENCY - 1) !rsp_strobe)

endmodule
